// ----- sv/rpdf_pkg.sv -----
// Shared types and constants for the row-to-page display flush block.
package rpdf_pkg;

    localparam int ROW_BITS    = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] PAGE_SELECT = 8'hB0;
    localparam logic [7:0] COLUMN_HIGH = 8'h10;
    localparam logic [7:0] COLUMN_LOW  = 8'h00;
    localparam logic [4:0] MAX_PAGES   = 5'd16;
    localparam logic [2:0] LAST_ROW    = 3'd7;

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_PAGES   = 1'b1;

    typedef enum logic [3:0] {
        PH_PAGE  = 4'b0001,
        PH_CHIGH = 4'b0010,
        PH_CLOW  = 4'b0100,
        PH_DATA  = 4'b1000
    } phase_t;

    // one queued page column: optional address header plus the data byte
    typedef struct packed {
        logic       hdr;
        logic [3:0] page;
        logic [7:0] data;
    } rec_t;

endpackage

// ----- sv/row_to_page_display_flush.sv -----
// Top level: row-major pixel stream to page-mode LCD bus words.
//
// Takes one pixel per cycle when not stalled. Rows 0 to 6 of a page are read-modify-written
// into a column line buffer (simple dual-port RAM, registered read,
// read at accept, write back in the following cycle, with a one-entry bypass for
// back-to-back hits on the same column). A row-7 pixel queues one record in a
// four-entry queue; the output side sends one word per cycle while out_stall is
// low, four words for column 0 (page select, column high, column low, data) and
// one otherwise. The first word of a row-7 pixel passes the stage-1 registers
// and the queue before it is on the bus. The input stalls while the queue,
// counting a record about to be written, holds four records. With a panel that
// never stalls this happens only in row 7 with four or more columns, once per
// page while the column-0 header drains; elsewhere the input takes one pixel per cycle.
module row_to_page_display_flush
    import rpdf_pkg::*;
#(
    parameter int MAX_COLUMNS = 128
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       pixel,
    input  logic       frame_start,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_data,
    output logic [7:0] bus_byte,
    output logic       last
);

    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [8:0] MAX_COL9 = 9'(MAX_COLUMNS);

    logic [7:0] columns_reg;
    logic [4:0] pages_reg;

    logic [CW-1:0] column_reg, column_next;
    logic [2:0]    row_reg, row_next;
    logic [3:0]    page_reg, page_next;

    logic [ROW_BITS-1:0] row_mem [MAX_COLUMNS];
    logic [ROW_BITS-1:0] rd_data_reg;

    logic                s1_valid_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [2:0]          s1_row_reg;
    logic                s1_pix_reg;
    logic [3:0]          s1_page_reg;

    logic                fwd_valid_reg;
    logic [CW-1:0]       fwd_col_reg;
    logic [ROW_BITS-1:0] fwd_data_reg;

    rec_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    phase_t            phase_reg;

    logic                in_acc;
    logic [CW-1:0]       col;
    logic [2:0]          row;
    logic [3:0]          page;
    logic [8:0]          eff_cols;
    logic [4:0]          eff_pages;
    logic [8:0]          col_inc;
    logic [4:0]          page_inc;
    logic [ROW_BITS-1:0] base;
    logic [ROW_BITS-1:0] s1_new;
    logic                s1_we;
    logic                s1_push;
    rec_t                s1_rec;
    rec_t                head;
    phase_t              eff_phase;
    logic                out_acc;
    logic                pop;
    logic [QCNT_W:0]     occupancy;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= 8'd128;
            pages_reg   <= 5'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COLUMNS: columns_reg <= cfg_data;
                CFG_PAGES:   pages_reg   <= cfg_data[4:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        if (columns_reg == 8'd0)
            eff_cols = 9'd1;
        else if ({1'b0, columns_reg} > MAX_COL9)
            eff_cols = MAX_COL9;
        else
            eff_cols = {1'b0, columns_reg};
        if (pages_reg == 5'd0)
            eff_pages = 5'd1;
        else if (pages_reg > MAX_PAGES)
            eff_pages = MAX_PAGES;
        else
            eff_pages = pages_reg;
    end

    // input side and position counters
    assign occupancy = (QCNT_W + 1)'(count_reg)
                     + (QCNT_W + 1)'(s1_valid_reg && s1_row_reg == LAST_ROW);
    assign in_stall  = occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH);
    assign in_acc    = in_valid && !in_stall;

    always_comb
    begin
        col  = frame_start ? '0 : column_reg;
        row  = frame_start ? 3'd0 : row_reg;
        page = frame_start ? 4'd0 : page_reg;
        col_inc  = 9'(col) + 9'd1;
        page_inc = {1'b0, page} + 5'd1;
        column_next = col_inc[CW-1:0];
        row_next    = row;
        page_next   = page;
        if (col_inc >= eff_cols)
        begin
            column_next = '0;
            row_next    = row + 3'd1;
            if (row == LAST_ROW)
                page_next = (page_inc >= eff_pages) ? 4'd0 : page_inc[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            row_reg      <= 3'd0;
            page_reg     <= 4'd0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc;
            if (in_acc)
            begin
                column_reg <= column_next;
                row_reg    <= row_next;
                page_reg   <= page_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_col_reg  <= col;
            s1_row_reg  <= row;
            s1_pix_reg  <= pixel;
            s1_page_reg <= page;
        end
    end

    // line buffer: read at accept, write back from stage 1
    always_ff @(posedge clk)
    begin
        if (in_acc)
            rd_data_reg <= row_mem[col];
        if (s1_we)
            row_mem[s1_col_reg] <= s1_new;
    end

    assign base = (fwd_valid_reg && fwd_col_reg == s1_col_reg) ? fwd_data_reg : rd_data_reg;

    always_comb
    begin
        s1_new = base;
        for (int k = 0; k < ROW_BITS; k++)
        begin
            if (3'(k) == s1_row_reg)
                s1_new[k] = s1_pix_reg;
        end
    end

    assign s1_we   = s1_valid_reg && s1_row_reg != LAST_ROW;
    assign s1_push = s1_valid_reg && s1_row_reg == LAST_ROW;

    assign s1_rec.hdr  = s1_col_reg == '0;
    assign s1_rec.page = s1_page_reg;
    assign s1_rec.data = ~{s1_pix_reg, base};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_valid_reg <= 1'b0;
        else
            fwd_valid_reg <= s1_we;
    end

    always_ff @(posedge clk)
    begin
        if (s1_we)
        begin
            fwd_col_reg  <= s1_col_reg;
            fwd_data_reg <= s1_new;
        end
    end

    // record queue and word sequencer
    always_ff @(posedge clk)
    begin
        if (s1_push)
            q_mem[wr_ptr_reg] <= s1_rec;
    end

    assign head      = q_mem[rd_ptr_reg];
    assign eff_phase = head.hdr ? phase_reg : PH_DATA;
    assign out_valid = count_reg != '0;
    assign out_acc   = out_valid && !out_stall;
    assign pop       = out_acc && eff_phase == PH_DATA;

    always_comb
    begin
        is_data  = 1'b0;
        last     = 1'b0;
        bus_byte = head.data;
        case (eff_phase)
            PH_PAGE:  bus_byte = PAGE_SELECT | {4'h0, head.page};
            PH_CHIGH: bus_byte = COLUMN_HIGH;
            PH_CLOW:  bus_byte = COLUMN_LOW;
            default:
            begin
                is_data  = 1'b1;
                last     = 1'b1;
                bus_byte = head.data;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= PH_PAGE;
        end
        else
        begin
            if (s1_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
                phase_reg  <= PH_PAGE;
            end
            else if (out_acc)
            begin
                case (phase_reg)
                    PH_PAGE:  phase_reg <= PH_CHIGH;
                    PH_CHIGH: phase_reg <= PH_CLOW;
                    default:  phase_reg <= PH_DATA;
                endcase
            end
            if (s1_push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !s1_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

// ----- sv/rpdf_checker.sv -----
// Port-level checker for the display flush block, with its bind.
module rpdf_checker
    import rpdf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       is_data,
    input logic [7:0] bus_byte,
    input logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bus_byte) && $stable(is_data)
                                   && $stable(last))
        else $error("stalled word changed");

    a_cmd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_data |-> !last)
        else $error("command word flagged last");

    a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_data |-> last)
        else $error("data word not flagged last");

    a_col_low_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !is_data && bus_byte == COLUMN_HIGH
        |=> out_valid && !is_data && bus_byte == COLUMN_LOW)
        else $error("column low command missing after column high");

endmodule

bind row_to_page_display_flush rpdf_checker u_rpdf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_data   (is_data),
    .bus_byte  (bus_byte),
    .last      (last)
);

// ----- tb/tb.sv -----
// Self-checking bench for row_to_page_display_flush: directed table, then random phases.
module tb;
    import rpdf_pkg::*;

    localparam int COLS_MAX    = 128;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 6;
    localparam int PHASES      = 6;
    localparam int STEPS       = 28;
    localparam int REPORT_CAP  = 60;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } panel_word_t;

    typedef struct packed {
        logic       cfg;
        logic       sel;
        logic [7:0] value;
        logic       pix;
        logic       fs;
        logic       typed;
        logic [7:0] page_byte;
        logic [7:0] data_byte;
    } step_t;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       cfg_we      = 1'b0;
    logic       cfg_index   = CFG_COLUMNS;
    logic [7:0] cfg_data    = 8'h00;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic       pixel       = 1'b0;
    logic       frame_start = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;

    // predicted panel state
    logic [6:0]  line_bits    [COLS_MAX];
    logic [6:0]  line_written [COLS_MAX];
    int          col_at, row_at, page_at;
    int          cols_reg, pages_reg;
    panel_word_t panel_words_due [$];

    int errors        = 0;
    int pixels_sent   = 0;
    int words_checked = 0;
    int cycle_count   = 0;
    int stall_left    = 0;
    bit tx_quiet      = 1'b0;
    bit rx_quiet      = 1'b0;

    // cols 1 / pages 2; typed rows are plain page bytes
    step_t steps [STEPS] = '{
        '{1'b1, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b1, CFG_PAGES,   8'd2, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b1, 1'b0, 1'b1, PAGE_SELECT, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b1, PAGE_SELECT + 8'd1, 8'hFF},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, CFG_COLUMNS, 8'd0, 1'b0, 1'b0, 1'b1, PAGE_SELECT, 8'hAA}
    };

    // the last phase keeps the position of the wide one, so a column past the new limit wraps
    int ph_cols  [PHASES] = '{1,   3,  5,  2,  200, 2};
    int ph_pages [PHASES] = '{17,  0,  31, 1,  2,   3};
    int ph_items [PHASES] = '{130, 24, 40, 16, 130, 20};
    int ph_noise [PHASES] = '{0,   20, 0,  30, 0,   10};

    row_to_page_display_flush #(.MAX_COLUMNS(COLS_MAX)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .frame_start(frame_start),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_data    (is_data),
        .bus_byte   (bus_byte),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int column_now();
        return (col_at >= COLS_MAX) ? 0 : col_at;
    endfunction

    task automatic flush_pixel(input logic pix, input logic fs,
                               output panel_word_t words [4], output int n);
        int         col;
        int         lim_c;
        int         lim_p;
        logic [7:0] column_byte;
        n = 0;
        if (fs)
        begin
            col_at  = 0;
            row_at  = 0;
            page_at = 0;
        end
        col = column_now();
        if (row_at < LAST_ROW)
        begin
            line_bits[col][row_at]    = pix;
            line_written[col][row_at] = 1'b1;
        end
        else
        begin
            if (col == 0)
            begin
                words[0] = '{1'b0, PAGE_SELECT + 8'(page_at % 16), 1'b0};
                words[1] = '{1'b0, COLUMN_HIGH, 1'b0};
                words[2] = '{1'b0, COLUMN_LOW, 1'b0};
                n = 3;
            end
            column_byte = ~{pix, line_bits[col]};
            words[n] = '{1'b1, column_byte, 1'b1};
            n++;
        end
        lim_c = (cols_reg == 0) ? 1 : ((cols_reg > COLS_MAX) ? COLS_MAX : cols_reg);
        lim_p = (pages_reg == 0) ? 1 : ((pages_reg > MAX_PAGES) ? MAX_PAGES : pages_reg);
        col_at = col + 1;
        if (col_at >= lim_c)
        begin
            col_at = 0;
            row_at = (row_at + 1) % 8;
            if (row_at == 0)
            begin
                page_at++;
                if (page_at >= lim_p)
                    page_at = 0;
            end
        end
    endtask

    // in_valid is left high after acceptance so back-to-back words need one assignment
    task automatic send_pixel(input logic pix, input logic fs, input logic typed,
                              input logic [7:0] page_byte, input logic [7:0] data_byte);
        panel_word_t words [4];
        int          n;
        int          gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel       <= pix;
        frame_start <= fs;
        do @(posedge clk); while (in_stall);
        flush_pixel(pix, fs, words, n);
        pixels_sent++;
        if (typed)
        begin
            panel_words_due.push_back('{1'b0, page_byte, 1'b0});
            panel_words_due.push_back('{1'b0, COLUMN_HIGH, 1'b0});
            panel_words_due.push_back('{1'b0, COLUMN_LOW, 1'b0});
            panel_words_due.push_back('{1'b1, data_byte, 1'b1});
        end
        else
        begin
            for (int i = 0; i < n; i++)
                panel_words_due.push_back(words[i]);
        end
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (panel_words_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= 8'(value);
        @(posedge clk);
        if (sel == CFG_COLUMNS)
            cols_reg = value & 255;
        else
            pages_reg = value & 31;
    endtask

    task automatic report(input string what, input int expv, input int gotv);
        errors++;
        if (errors <= REPORT_CAP)
            $display("%0t: %s expected %02h got %02h", $time, what, expv, gotv);
    endtask

    always @(posedge clk)
    begin : word_check
        panel_word_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (panel_words_due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: word with nothing due: expected none got %0b/%02h/%0b",
                             $time, is_data, bus_byte, last);
            end
            else
            begin
                due = panel_words_due.pop_front();
                words_checked++;
                if (is_data !== due.is_data)
                    report("is_data", due.is_data, is_data);
                if (bus_byte !== due.bus_byte)
                    report("bus_byte", due.bus_byte, bus_byte);
                if (last !== due.last)
                    report("last", due.last, last);
            end
        end
    end

    always @(posedge clk)
    begin : word_stall
        int n;
        if (out_stall)
        begin
            if (stall_left <= 1)
                out_stall <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (out_valid)
        begin
            n = rx_quiet ? 0 : $urandom_range(0, 4);
            if (n > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= n;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic pix;
        logic fs;
        bit   in_cfg;
        cols_reg  = 128;
        pages_reg = 8;
        col_at    = 0;
        row_at    = 0;
        page_at   = 0;
        in_cfg    = 1'b0;
        for (int c = 0; c < COLS_MAX; c++)
            line_written[c] = 7'h00;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < STEPS; i++)
        begin
            if (steps[i].cfg)
            begin
                if (!in_cfg)
                    drain_and_settle();
                write_reg(steps[i].sel, steps[i].value);
                in_cfg = 1'b1;
            end
            else
            begin
                if (in_cfg)
                    cfg_we <= 1'b0;
                in_cfg = 1'b0;
                send_pixel(steps[i].pix, steps[i].fs, steps[i].typed,
                           steps[i].page_byte, steps[i].data_byte);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_and_settle();
            write_reg(CFG_COLUMNS, ph_cols[p]);
            write_reg(CFG_PAGES, ph_pages[p]);
            cfg_we   <= 1'b0;
            tx_quiet  = ($urandom_range(0, 3) == 0);
            rx_quiet <= ($urandom_range(0, 3) == 0);
            for (int k = 0; k < ph_items[p]; k++)
            begin
                pix = $urandom_range(0, 1);
                if (ph_noise[p] == 0)
                    fs = (k == 0);
                else if (col_at == 0 && row_at == 0 && page_at == 0)
                    fs = $urandom_range(0, 1);
                else
                    fs = ($urandom_range(0, 999) < ph_noise[p]);
                // never let a row-7 word read line buffer bits that were not written
                if (!fs && row_at == LAST_ROW && line_written[column_now()] != 7'h7F)
                    fs = 1'b1;
                send_pixel(pix, fs, 1'b0, 8'h00, 8'h00);
            end
        end

        drain_and_settle();
        $display("Sent %0d pixels: directed table plus %0d setting phases; %0d words checked.",
                 pixels_sent, PHASES, words_checked);
        $display("Column limits 0 to 200, page limits 0 to 31, page wrap, limits lowered");
        $display("mid-frame, mid-page frame restarts, full output queue, stalls on both sides.");
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
sv/rpdf_pkg.sv
sv/row_to_page_display_flush.sv
sv/rpdf_checker.sv
tb/tb.sv
